// File: rtl/core/stlbc_pkg.sv
package stlbc_pkg;

    // Machine state codes
    localparam logic [2:0] ST_STOP  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_ERROR = 3'd2;
    localparam logic [2:0] ST_CYCLE = 3'd3;
    localparam logic [2:0] ST_ALARM = 3'd4;

    localparam int NUM_PATTERNS = 5;
    localparam int STATE_W      = 3;
    localparam int PATTERN_W    = 9;
    localparam int ON_TIME_W    = 24;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int BUZZ_LINES   = 5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_PATTERN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_PATTERN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_PATTERN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_PATTERN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_PATTERN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BUZZER_ON     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BUZZER_SKIP   = 3'd6;

    // Reset values of the configuration registers
    localparam logic [PATTERN_W-1:0] STOP_PATTERN_RST  = 9'd4;
    localparam logic [PATTERN_W-1:0] RUN_PATTERN_RST   = 9'd1;
    localparam logic [PATTERN_W-1:0] ERROR_PATTERN_RST = 9'd80;
    localparam logic [PATTERN_W-1:0] CYCLE_PATTERN_RST = 9'd16;
    localparam logic [PATTERN_W-1:0] ALARM_PATTERN_RST = 9'd9;
    localparam logic [ON_TIME_W-1:0] BUZZER_ON_RST     = 24'd3600;

    localparam int BLINK_HALF_DEFAULT = 500;
    localparam int TIMER_BITS_DEFAULT = 24;

    // Lamp modes
    localparam logic [1:0] LAMP_DARK = 2'd0;
    localparam logic [1:0] LAMP_ON   = 2'd1;

    typedef logic [PATTERN_W-1:0] pattern_t;
    typedef logic [STATE_W-1:0]   state_t;

    // Control word from the top level to the buzzer timer
    typedef struct packed {
        logic   advance;
        logic   mute_request;
        logic   skip;
        state_t state;
    } buzz_ctl_t;

    function automatic logic lamp_drive(input logic [1:0] mode, input logic phase);
        logic drive;
        case (mode)
            LAMP_DARK: drive = 1'b0;
            LAMP_ON:   drive = 1'b1;
            default:   drive = phase;
        endcase
        return drive;
    endfunction

endpackage

// File: rtl/core/stlbc_decode.sv
module stlbc_decode (
    input  logic                auto_mode,
    input  logic                cycle_running,
    input  logic                warning_present,
    input  logic                error_present,
    input  stlbc_pkg::pattern_t pattern_tab [stlbc_pkg::NUM_PATTERNS],
    output stlbc_pkg::state_t   state,
    output stlbc_pkg::pattern_t pattern
);

    // Priority: auto first, then cycle run, then error, else stop
    always_comb
    begin
        if (auto_mode)
        begin
            state = warning_present ? stlbc_pkg::ST_ALARM : stlbc_pkg::ST_RUN;
        end
        else if (cycle_running)
        begin
            state = stlbc_pkg::ST_CYCLE;
        end
        else if (error_present)
        begin
            state = stlbc_pkg::ST_ERROR;
        end
        else
        begin
            state = stlbc_pkg::ST_STOP;
        end
    end

    always_comb
    begin
        unique case (state)
            stlbc_pkg::ST_STOP:  pattern = pattern_tab[0];
            stlbc_pkg::ST_RUN:   pattern = pattern_tab[1];
            stlbc_pkg::ST_ERROR: pattern = pattern_tab[2];
            stlbc_pkg::ST_CYCLE: pattern = pattern_tab[3];
            default:             pattern = pattern_tab[4];
        endcase
    end

endmodule

// File: rtl/core/stlbc_blink.sv
module stlbc_blink #(
    parameter int BLINK_HALF_TICKS = stlbc_pkg::BLINK_HALF_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    output logic phase
);

    localparam int PERIOD  = 2 * BLINK_HALF_TICKS;
    localparam int COUNT_W = $clog2(PERIOD);
    localparam logic [COUNT_W-1:0] COUNT_TOP  = COUNT_W'(PERIOD - 1);
    localparam logic [COUNT_W-1:0] COUNT_HALF = COUNT_W'(BLINK_HALF_TICKS);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign phase = (count_reg < COUNT_HALF);

    // Advance once per tick, wrap at the end of the off half
    always_comb
    begin
        count_next = count_reg;
        if (advance)
        begin
            count_next = (count_reg == COUNT_TOP) ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_blink_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (count_reg == COUNT_TOP) |=> (count_reg == '0))
        else $error("blink counter did not wrap");

endmodule

// File: rtl/core/stlbc_buzzer.sv
module stlbc_buzzer #(
    parameter int TIMER_BITS = stlbc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stlbc_pkg::buzz_ctl_t                ctl,
    input  logic [2:0]                          buzzer_num,
    input  logic [stlbc_pkg::ON_TIME_W-1:0]     on_time,
    output logic [stlbc_pkg::BUZZ_LINES-1:0]    lines
);

    localparam int CMP_W = (TIMER_BITS > stlbc_pkg::ON_TIME_W) ?
                           TIMER_BITS : stlbc_pkg::ON_TIME_W;

    logic [TIMER_BITS-1:0] elapsed_reg;
    logic [TIMER_BITS-1:0] elapsed_next;
    stlbc_pkg::state_t     prev_state_reg;
    logic                  muted_reg;
    logic                  muted_next;

    logic                  changed;
    logic                  muted_eff;
    logic [TIMER_BITS-1:0] elapsed_eff;
    logic                  expired;
    logic                  sound;

    assign changed = (ctl.state != prev_state_reg);

    // Mute request first, then state change clears it, then skip forces it
    assign muted_eff   = ctl.skip | (~changed & (muted_reg | ctl.mute_request));
    assign elapsed_eff = changed ? '0 : elapsed_reg;
    assign expired     = (on_time != '0) &&
                         (CMP_W'(elapsed_eff) >= CMP_W'(on_time));
    assign sound       = ~muted_eff & ~expired;

    always_comb
    begin
        if (muted_eff)
        begin
            elapsed_next = '0;
        end
        else if (expired || (&elapsed_eff))
        begin
            elapsed_next = elapsed_eff;
        end
        else
        begin
            elapsed_next = elapsed_eff + 1'b1;
        end
        muted_next = muted_eff;
    end

    always_comb
    begin
        lines = '0;
        if (sound)
        begin
            unique case (buzzer_num)
                3'd1:    lines = 5'b00001;
                3'd2:    lines = 5'b00010;
                3'd3:    lines = 5'b00100;
                3'd4:    lines = 5'b01000;
                3'd5:    lines = 5'b10000;
                default: lines = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg    <= '0;
            prev_state_reg <= stlbc_pkg::ST_STOP;
            muted_reg      <= 1'b1;
        end
        else if (ctl.advance)
        begin
            elapsed_reg    <= elapsed_next;
            prev_state_reg <= ctl.state;
            muted_reg      <= muted_next;
        end
    end

    a_lines_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(lines))
        else $error("more than one buzzer line driven");

    a_skip_mutes: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.advance && ctl.skip |=> muted_reg && (elapsed_reg == '0))
        else $error("skip did not latch mute and clear the timer");

endmodule

// File: rtl/core/signal_tower_lamp_buzzer_control.sv
// Path: a word accepted at the input goes to the input register, then to the
// result register, and waits in the input register while a stalled result holds it.
// Throughput: one word per cycle; the input register takes one more word
// while a finished word waits on out_stall, then the input is held.
// Reset (rst_n, async, active low): both stages empty, patterns and timers at defaults,
// blink at the start of its on half, buzzer muted, last state stop.
module signal_tower_lamp_buzzer_control #(
    parameter int BLINK_HALF_TICKS = stlbc_pkg::BLINK_HALF_DEFAULT,
    parameter int TIMER_BITS       = stlbc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_we,
    input  logic [stlbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stlbc_pkg::CFG_DATA_W-1:0]     cfg_data,

    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 auto_mode,
    input  logic                                 cycle_running,
    input  logic                                 warning_present,
    input  logic                                 error_present,
    input  logic                                 mute_request,

    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 green_lamp,
    output logic                                 yellow_lamp,
    output logic                                 red_lamp,
    output logic [stlbc_pkg::BUZZ_LINES-1:0]     buzzer_lines,
    output logic [stlbc_pkg::STATE_W-1:0]        machine_state,
    output logic                                 blink_phase
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    stlbc_pkg::pattern_t                pattern_reg [stlbc_pkg::NUM_PATTERNS];
    logic [stlbc_pkg::ON_TIME_W-1:0]    on_time_reg;
    logic                               skip_reg;

    // Take a write on any enable; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg[0] <= stlbc_pkg::STOP_PATTERN_RST;
            pattern_reg[1] <= stlbc_pkg::RUN_PATTERN_RST;
            pattern_reg[2] <= stlbc_pkg::ERROR_PATTERN_RST;
            pattern_reg[3] <= stlbc_pkg::CYCLE_PATTERN_RST;
            pattern_reg[4] <= stlbc_pkg::ALARM_PATTERN_RST;
            on_time_reg    <= stlbc_pkg::BUZZER_ON_RST;
            skip_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stlbc_pkg::REG_STOP_PATTERN:
                    pattern_reg[0] <= cfg_data[stlbc_pkg::PATTERN_W-1:0];
                stlbc_pkg::REG_RUN_PATTERN:
                    pattern_reg[1] <= cfg_data[stlbc_pkg::PATTERN_W-1:0];
                stlbc_pkg::REG_ERROR_PATTERN:
                    pattern_reg[2] <= cfg_data[stlbc_pkg::PATTERN_W-1:0];
                stlbc_pkg::REG_CYCLE_PATTERN:
                    pattern_reg[3] <= cfg_data[stlbc_pkg::PATTERN_W-1:0];
                stlbc_pkg::REG_ALARM_PATTERN:
                    pattern_reg[4] <= cfg_data[stlbc_pkg::PATTERN_W-1:0];
                stlbc_pkg::REG_BUZZER_ON:
                    on_time_reg    <= cfg_data[stlbc_pkg::ON_TIME_W-1:0];
                stlbc_pkg::REG_BUZZER_SKIP:
                    skip_reg       <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic load;

    // Advance the input word when the result register is empty or being drained
    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    // Hold the input side only while a word sits in the input register and cannot move
    assign in_stall = in_valid_reg & ~advance;
    assign load     = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register (payload, no reset)
    // ------------------------------------------------------------------
    logic auto_reg;
    logic cycle_reg;
    logic warn_reg;
    logic err_reg;
    logic mute_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            auto_reg  <= auto_mode;
            cycle_reg <= cycle_running;
            warn_reg  <= warning_present;
            err_reg   <= error_present;
            mute_reg  <= mute_request;
        end
    end

    // ------------------------------------------------------------------
    // Per-tick work: state decode, blink wave, buzzer timer
    // ------------------------------------------------------------------
    stlbc_pkg::state_t    state;
    stlbc_pkg::pattern_t  pattern;
    logic                 phase;
    logic [stlbc_pkg::BUZZ_LINES-1:0] lines;
    stlbc_pkg::buzz_ctl_t buzz_ctl;

    stlbc_decode u_decode (
        .auto_mode       (auto_reg),
        .cycle_running   (cycle_reg),
        .warning_present (warn_reg),
        .error_present   (err_reg),
        .pattern_tab     (pattern_reg),
        .state           (state),
        .pattern         (pattern)
    );

    stlbc_blink #(
        .BLINK_HALF_TICKS (BLINK_HALF_TICKS)
    ) u_blink (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .phase   (phase)
    );

    assign buzz_ctl.advance      = advance;
    assign buzz_ctl.mute_request = mute_reg;
    assign buzz_ctl.skip         = skip_reg;
    assign buzz_ctl.state        = state;

    stlbc_buzzer #(
        .TIMER_BITS (TIMER_BITS)
    ) u_buzzer (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (buzz_ctl),
        .buzzer_num (pattern[8:6]),
        .on_time    (on_time_reg),
        .lines      (lines)
    );

    // ------------------------------------------------------------------
    // Result register (payload, no reset)
    // ------------------------------------------------------------------
    logic                             green_reg;
    logic                             yellow_reg;
    logic                             red_reg;
    logic [stlbc_pkg::BUZZ_LINES-1:0] lines_reg;
    stlbc_pkg::state_t                state_reg;
    logic                             phase_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            green_reg  <= stlbc_pkg::lamp_drive(pattern[1:0], phase);
            yellow_reg <= stlbc_pkg::lamp_drive(pattern[3:2], phase);
            red_reg    <= stlbc_pkg::lamp_drive(pattern[5:4], phase);
            lines_reg  <= lines;
            state_reg  <= state;
            phase_reg  <= phase;
        end
    end

    assign out_valid     = out_valid_reg;
    assign green_lamp    = green_reg;
    assign yellow_lamp   = yellow_reg;
    assign red_lamp      = red_reg;
    assign buzzer_lines  = lines_reg;
    assign machine_state = state_reg;
    assign blink_phase   = phase_reg;

endmodule

// File: verif/tower_output_checker.sv
module tower_output_checker #(
    parameter int BLINK_HALF_TICKS = stlbc_pkg::BLINK_HALF_DEFAULT,
    parameter int TIMER_BITS       = stlbc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stlbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [stlbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              auto_mode,
    input  logic                              cycle_running,
    input  logic                              warning_present,
    input  logic                              error_present,
    input  logic                              mute_request,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              green_lamp,
    input  logic                              yellow_lamp,
    input  logic                              red_lamp,
    input  logic [stlbc_pkg::BUZZ_LINES-1:0]  buzzer_lines,
    input  logic [stlbc_pkg::STATE_W-1:0]     machine_state,
    input  logic                              blink_phase,
    output int                                fail_count,
    output int                                words_pending,
    output int                                words_checked,
    output int                                buzz_words
);
    import stlbc_pkg::*;

    typedef struct packed {
        logic                  green;
        logic                  yellow;
        logic                  red;
        logic [BUZZ_LINES-1:0] buzz;
        state_t                st;
        logic                  phase;
    } tower_word_t;

    tower_word_t           words_due[$];
    pattern_t              patterns[NUM_PATTERNS];
    logic [ON_TIME_W-1:0]  on_time;
    logic                  skip;
    int                    blink_ticks;
    logic [TIMER_BITS-1:0] buzz_elapsed;
    state_t                last_state;
    logic                  muted;
    tower_word_t           due;
    pattern_t              pat;
    logic [2:0]            buzz_num;

    initial
    begin
        fail_count    = 0;
        words_pending = 0;
        words_checked = 0;
        buzz_words    = 0;
    end

    function automatic logic lamp_level(input logic [1:0] mode, input logic phase);
        if (mode == LAMP_DARK)
            return 1'b0;
        if (mode == LAMP_ON)
            return 1'b1;
        return phase;
    endfunction

    // print the first few, count all
    task automatic report_mismatch(input string field, input int got, input int want);
        if (fail_count < 40)
            $display("tower check: word %0d %s got %0d want %0d",
                     words_checked, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patterns[ST_STOP]  = STOP_PATTERN_RST;
            patterns[ST_RUN]   = RUN_PATTERN_RST;
            patterns[ST_ERROR] = ERROR_PATTERN_RST;
            patterns[ST_CYCLE] = CYCLE_PATTERN_RST;
            patterns[ST_ALARM] = ALARM_PATTERN_RST;
            on_time            = BUZZER_ON_RST;
            skip               = 1'b0;
            blink_ticks        = 0;
            buzz_elapsed       = '0;
            last_state         = ST_STOP;
            muted              = 1'b1;
            words_due.delete();
            words_pending     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STOP_PATTERN, REG_RUN_PATTERN, REG_ERROR_PATTERN,
                    REG_CYCLE_PATTERN, REG_ALARM_PATTERN:
                        patterns[cfg_index] = cfg_data[PATTERN_W-1:0];
                    REG_BUZZER_ON:   on_time = cfg_data[ON_TIME_W-1:0];
                    REG_BUZZER_SKIP: skip = cfg_data[0];
                    default: ;
                endcase
            end

            // compare before queuing, so a word that arrives too early is not
            // matched against the tick accepted at this very edge
            if (out_valid && !out_stall)
            begin
                if (words_due.size() == 0)
                    report_mismatch("word with nothing due", 1, 0);
                else
                begin
                    due = words_due.pop_front();
                    if (green_lamp !== due.green)
                        report_mismatch("green_lamp", green_lamp, due.green);
                    if (yellow_lamp !== due.yellow)
                        report_mismatch("yellow_lamp", yellow_lamp, due.yellow);
                    if (red_lamp !== due.red)
                        report_mismatch("red_lamp", red_lamp, due.red);
                    if (buzzer_lines !== due.buzz)
                        report_mismatch("buzzer_lines", buzzer_lines, due.buzz);
                    if (machine_state !== due.st)
                        report_mismatch("machine_state", machine_state, due.st);
                    if (blink_phase !== due.phase)
                        report_mismatch("blink_phase", blink_phase, due.phase);
                    words_checked++;
                    if (due.buzz != '0)
                        buzz_words++;
                end
            end

            if (in_valid && !in_stall)
            begin
                due.phase = (blink_ticks < BLINK_HALF_TICKS);
                blink_ticks = (blink_ticks + 1 == 2 * BLINK_HALF_TICKS) ? 0 : blink_ticks + 1;

                if (mute_request)
                    muted = 1'b1;

                if (auto_mode)
                    due.st = warning_present ? ST_ALARM : ST_RUN;
                else if (cycle_running)
                    due.st = ST_CYCLE;
                else if (error_present)
                    due.st = ST_ERROR;
                else
                    due.st = ST_STOP;

                if (due.st != last_state)
                begin
                    buzz_elapsed = '0;
                    last_state   = due.st;
                    muted        = 1'b0;
                end
                if (skip)
                    muted = 1'b1;

                pat        = patterns[due.st];
                due.green  = lamp_level(pat[1:0], due.phase);
                due.yellow = lamp_level(pat[3:2], due.phase);
                due.red    = lamp_level(pat[5:4], due.phase);
                due.buzz   = '0;

                if (muted)
                    buzz_elapsed = '0;
                else if (!(on_time != '0 && buzz_elapsed >= on_time))
                begin
                    buzz_num = pat[8:6];
                    if (buzz_num >= 1 && buzz_num <= BUZZ_LINES)
                        due.buzz = BUZZ_LINES'(1) << (buzz_num - 1);
                    if (buzz_elapsed != '1)
                        buzz_elapsed++;
                end
                words_due.push_back(due);
            end
            words_pending <= words_due.size();
        end
    end

endmodule

// File: verif/signal_tower_lamp_buzzer_control_tb.sv
module signal_tower_lamp_buzzer_control_tb;
    import stlbc_pkg::*;

    localparam int BLINK_HALF        = 500;
    localparam int TIMER_W           = 24;
    localparam int NUM_SETTINGS      = 8;
    localparam int ITEMS_PER_SETTING = 200;
    localparam int RUN_LIMIT         = 300000;

    // index past the end of the register list; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    // one tick word as the machine flags come in
    typedef struct packed {
        logic auto_on;
        logic cycle_on;
        logic warn_on;
        logic err_on;
        logic mute_on;
    } tick_flags_t;

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;
    logic                   cfg_we          = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index       = '0;
    logic [CFG_DATA_W-1:0]  cfg_data        = '0;
    logic                   in_valid        = 1'b0;
    logic                   in_stall;
    logic                   auto_mode       = 1'b0;
    logic                   cycle_running   = 1'b0;
    logic                   warning_present = 1'b0;
    logic                   error_present   = 1'b0;
    logic                   mute_request    = 1'b0;
    logic                   out_valid;
    logic                   out_stall       = 1'b0;
    logic                   green_lamp;
    logic                   yellow_lamp;
    logic                   red_lamp;
    logic [BUZZ_LINES-1:0]  buzzer_lines;
    logic [STATE_W-1:0]     machine_state;
    logic                   blink_phase;

    int fail_count;
    int words_pending;
    int words_checked;
    int buzz_words;
    int items_sent  = 0;
    int cycle_count = 0;
    bit quiet       = 1'b0;

    always #5 clk = ~clk;

    signal_tower_lamp_buzzer_control #(
        .BLINK_HALF_TICKS (BLINK_HALF),
        .TIMER_BITS       (TIMER_W)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .auto_mode       (auto_mode),
        .cycle_running   (cycle_running),
        .warning_present (warning_present),
        .error_present   (error_present),
        .mute_request    (mute_request),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .green_lamp      (green_lamp),
        .yellow_lamp     (yellow_lamp),
        .red_lamp        (red_lamp),
        .buzzer_lines    (buzzer_lines),
        .machine_state   (machine_state),
        .blink_phase     (blink_phase)
    );

    tower_output_checker #(
        .BLINK_HALF_TICKS (BLINK_HALF),
        .TIMER_BITS       (TIMER_W)
    ) u_tower_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .auto_mode       (auto_mode),
        .cycle_running   (cycle_running),
        .warning_present (warning_present),
        .error_present   (error_present),
        .mute_request    (mute_request),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .green_lamp      (green_lamp),
        .yellow_lamp     (yellow_lamp),
        .red_lamp        (red_lamp),
        .buzzer_lines    (buzzer_lines),
        .machine_state   (machine_state),
        .blink_phase     (blink_phase),
        .fail_count      (fail_count),
        .words_pending   (words_pending),
        .words_checked   (words_checked),
        .buzz_words      (buzz_words)
    );

    // Hard stop: a hung handshake or a lost word ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("signal_tower_lamp_buzzer_control_tb: errors");
            $finish;
        end
    end

    // Drive one tick word: idle a random number of cycles first (none in a
    // quiet stretch), then hold valid and the flags until the block takes it.
    // Valid is only dropped when a gap is drawn, so back-to-back words keep
    // it high without a second assignment in the same step.
    task automatic send_tick(input tick_flags_t f);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        auto_mode       <= f.auto_on;
        cycle_running   <= f.cycle_on;
        warning_present <= f.warn_on;
        error_present   <= f.err_on;
        mute_request    <= f.mute_on;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Write one register; the enable stays high across a burst of writes and
    // is dropped by the caller after the last one.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Drop valid and wait until every predicted word has come out, then let
    // the pipeline settle for the caller's tail. Step once before looking at
    // the pending count so the word taken at this edge is already counted.
    task automatic drain(input int tail);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    // Result side: stall a random number of cycles ahead of every word, then
    // release and hold the stall low until one word has been taken.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 8);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        tick_flags_t            f;
        state_t                 target;
        int                     run_len;
        int                     phase_items;
        logic [ON_TIME_W-1:0]   on_time;
        logic                   skip;
        logic [CFG_INDEX_W-1:0] r;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: walk every combination of the
        // four machine flags, so each priority branch is taken at least once and
        // the state changes along the way.
        for (int i = 0; i < 16; i++)
            send_tick(tick_flags_t'({i[3:0], 1'b0}));

        // Error sounds buzzer 1 by default: restart it, mute it while the
        // state holds, check mute sticks, then show a state change clears a
        // mute raised in the same tick.
        f = '0;
        f.err_on = 1'b1;
        send_tick(f);
        f.mute_on = 1'b1;
        send_tick(f);
        f.mute_on = 1'b0;
        send_tick(f);
        f = '0;
        f.auto_on = 1'b1;
        f.warn_on = 1'b1;
        f.mute_on = 1'b1;
        send_tick(f);
        drain(4);

        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            // Pick the buzzer limits: unlimited, one tick, short, full scale.
            case (ph)
                0:       on_time = ON_TIME_W'($urandom_range(1, 40));
                1:       on_time = '0;
                2:       on_time = '1;
                3:       on_time = ON_TIME_W'(1);
                4:       on_time = ON_TIME_W'($urandom_range(1, 60));
                5:       on_time = '0;
                6:       on_time = ON_TIME_W'($urandom());
                default: on_time = ON_TIME_W'($urandom_range(2, 20));
            endcase
            skip = (ph == 2) ? 1'b1 : (ph == 6) ? 1'(($urandom_range(0, 1))) : 1'b0;

            // Patterns: all ones (blink everywhere, buzzer seven), all zeros
            // (lamps off, no buzzer), else full-width random data so the
            // bits above each register's width get masked.
            for (r = REG_STOP_PATTERN; r <= REG_ALARM_PATTERN; r++)
                write_reg(r, (ph == 1) ? '1 : (ph == 2) ? '0 : CFG_DATA_W'($urandom()));
            write_reg(REG_BUZZER_ON, on_time);
            write_reg(REG_BUZZER_SKIP, {{(CFG_DATA_W-1){1'b0}}, skip});
            write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
            cfg_we <= 1'b0;
            @(posedge clk);

            // Every third setting runs with no idling on either side.
            quiet = (ph % 3 == 2);

            // Hold a target state for a run of ticks so the buzzer timer
            // gets to expire; the flags that do not decide the state stay
            // random. Mix in a share of fully random ticks as noise.
            phase_items = 0;
            while (phase_items < ITEMS_PER_SETTING)
            begin
                target  = state_t'($urandom_range(ST_STOP, ST_ALARM));
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 30);
                for (int n = 0; n < run_len; n++)
                begin
                    f = tick_flags_t'($urandom());
                    if ($urandom_range(0, 6) != 0)
                    begin
                        case (target)
                            ST_RUN:
                            begin
                                f.auto_on = 1'b1;
                                f.warn_on = 1'b0;
                            end
                            ST_ALARM:
                            begin
                                f.auto_on = 1'b1;
                                f.warn_on = 1'b1;
                            end
                            ST_CYCLE:
                            begin
                                f.auto_on  = 1'b0;
                                f.cycle_on = 1'b1;
                            end
                            ST_ERROR:
                            begin
                                f.auto_on  = 1'b0;
                                f.cycle_on = 1'b0;
                                f.err_on   = 1'b1;
                            end
                            default:
                            begin
                                f.auto_on  = 1'b0;
                                f.cycle_on = 1'b0;
                                f.err_on   = 1'b0;
                            end
                        endcase
                        f.mute_on = ($urandom_range(0, 15) == 0);
                    end
                    send_tick(f);
                    phase_items++;
                end
            end
            drain(4);
        end

        drain(8);
        $display("Covered %0d tick words over %0d register settings plus reset defaults;",
                 items_sent, NUM_SETTINGS);
        $display("%0d results compared, %0d of them with a buzzer line driven.",
                 words_checked, buzz_words);
        if (fail_count == 0)
            $display("signal_tower_lamp_buzzer_control_tb: clean");
        else
            $display("signal_tower_lamp_buzzer_control_tb: errors");
        $finish;
    end

endmodule
